@@ rtl/grd_pkg.sv @@
// Shared types and constants for the graph diameter and radius block.
package grd_pkg;

  localparam int DistW = 27;
  localparam int EntryW = 17;
  localparam int VcountW = 7;

  localparam logic [DistW-1:0] DistInf = 27'd100000000;
  localparam logic [VcountW-1:0] VcountReset = 7'd64;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_LD_CMP   = 9'b000000010,
    ST_LD_WR2   = 9'b000000100,
    ST_FW_IK    = 9'b000001000,
    ST_FW_IKW   = 9'b000010000,
    ST_FW_ROW   = 9'b000100000,
    ST_FW_DRAIN = 9'b001000000,
    ST_EC_ROW   = 9'b010000000,
    ST_EC_FIN   = 9'b100000000
  } state_e;

endpackage

@@ rtl/graph_radius_diameter.sv @@
// Graph diameter and radius: matrix load, Floyd-Warshall pass and eccentricity sweep.
// An entry on or above the diagonal is written as taken, the diagonal as zero; one below it is
// compared with its mirror, the smaller is written to both, and only then is start taken again.
// After the last entry the pass and sweep run on the single distance memory; busy stays high.
// The result is shown for one cycle on done_o and cannot be held off by the receiver.
// Reset clears the sequencer and counters and sets vertex_count to 64; the memory is not cleared.
module graph_radius_diameter #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [grd_pkg::EntryW-1:0]   matrix_entry_i,
  output logic                                done_o,
  output logic        [grd_pkg::DistW-1:0]    diameter_o,
  output logic        [grd_pkg::DistW-1:0]    radius_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [grd_pkg::VcountW-1:0]  cfg_data_i
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW = 2 * IW;
  localparam int Depth = 1 << AW;
  localparam int DW = grd_pkg::DistW;
  localparam logic [IW-1:0] LastMax = IW'(MAX_VERTICES - 1);

  grd_pkg::state_e state_q, state_d;

  logic [grd_pkg::VcountW-1:0] vcount_q, vcount_d;
  logic [IW-1:0] n_last;
  logic [IW-1:0] row_q, row_d, col_q, col_d;
  logic [IW-1:0] ld_r_q, ld_r_d, ld_c_q, ld_c_d;
  logic last_q, last_d;
  logic [IW-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic s1_valid_q, s1_valid_d, s2_valid_q, s2_valid_d;
  logic e_valid_q, e_valid_d;
  logic done_q, done_d;
  logic [IW-1:0] s1_j_q, s2_j_q;
  logic [DW-1:0] w_q, w_d, m_q, m_d, dik_q, dik_d;
  logic [DW-1:0] via_q, dij_q;
  logic [DW-1:0] ecc_q, ecc_d, largest_q, largest_d, smallest_q, smallest_d;
  logic [DW-1:0] diameter_q, diameter_d, radius_q, radius_d;

  logic [DW-1:0] mem [Depth];
  logic [DW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic [DW-1:0] wdata;
  logic we;

  logic [DW-1:0] entry_w, ld_min, via_sum, ecc_new;
  logic [DW:0] sum_wide;
  logic accept;

  assign accept = start && (state_q == grd_pkg::ST_IDLE);
  assign busy = (state_q != grd_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == grd_pkg::ST_IDLE);
  assign done_o = done_q;
  assign diameter_o = diameter_q;
  assign radius_o = radius_q;

  always_comb begin
    if (vcount_q == '0) begin
      n_last = '0;
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      n_last = LastMax;
    end else begin
      n_last = IW'(vcount_q - 7'd1);
    end
  end

  assign entry_w = (matrix_entry_i[grd_pkg::EntryW-1] || matrix_entry_i == '0) ?
                   grd_pkg::DistInf : {{(DW-16){1'b0}}, matrix_entry_i[15:0]};
  assign ld_min = (rd_a_q < w_q) ? rd_a_q : w_q;
  assign sum_wide = {1'b0, dik_q} + {1'b0, rd_a_q};
  assign via_sum = (sum_wide > {1'b0, grd_pkg::DistInf}) ? grd_pkg::DistInf :
                   sum_wide[DW-1:0];
  assign ecc_new = (e_valid_q && rd_a_q > ecc_q) ? rd_a_q : ecc_q;

  always_comb begin
    state_d = state_q;
    vcount_d = vcount_q;
    row_d = row_q;
    col_d = col_q;
    ld_r_d = ld_r_q;
    ld_c_d = ld_c_q;
    last_d = last_q;
    k_d = k_q;
    i_d = i_q;
    j_d = j_q;
    w_d = w_q;
    m_d = m_q;
    dik_d = dik_q;
    ecc_d = ecc_q;
    largest_d = largest_q;
    smallest_d = smallest_q;
    diameter_d = diameter_q;
    radius_d = radius_q;
    done_d = 1'b0;
    s1_valid_d = 1'b0;
    e_valid_d = 1'b0;
    raddr_a = {i_q, k_q};
    raddr_b = {i_q, j_q};
    waddr = {row_q, col_q};
    wdata = '0;
    we = 1'b0;

    case (state_q)
      grd_pkg::ST_IDLE: begin
        if (accept) begin
          ld_r_d = row_q;
          ld_c_d = col_q;
          w_d = entry_w;
          last_d = (row_q == n_last) && (col_q == n_last);
          if (col_q == n_last) begin
            col_d = '0;
            row_d = (row_q == n_last) ? '0 : row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          k_d = '0;
          i_d = '0;
          if (row_q > col_q) begin
            raddr_a = {col_q, row_q};
            state_d = grd_pkg::ST_LD_CMP;
          end else begin
            we = 1'b1;
            waddr = {row_q, col_q};
            wdata = (row_q == col_q) ? '0 : entry_w;
            if (last_d) begin
              state_d = grd_pkg::ST_FW_IK;
            end
          end
        end
        if (cfg_valid_i) begin
          vcount_d = cfg_data_i;
          row_d = '0;
          col_d = '0;
        end
      end
      grd_pkg::ST_LD_CMP: begin
        we = 1'b1;
        waddr = {ld_r_q, ld_c_q};
        wdata = ld_min;
        m_d = ld_min;
        state_d = grd_pkg::ST_LD_WR2;
      end
      grd_pkg::ST_LD_WR2: begin
        we = 1'b1;
        waddr = {ld_c_q, ld_r_q};
        wdata = m_q;
        state_d = last_q ? grd_pkg::ST_FW_IK : grd_pkg::ST_IDLE;
      end
      grd_pkg::ST_FW_IK: begin
        raddr_a = {i_q, k_q};
        state_d = grd_pkg::ST_FW_IKW;
      end
      grd_pkg::ST_FW_IKW, grd_pkg::ST_FW_DRAIN: begin
        if (state_q == grd_pkg::ST_FW_IKW && rd_a_q < grd_pkg::DistInf) begin
          dik_d = rd_a_q;
          j_d = '0;
          state_d = grd_pkg::ST_FW_ROW;
        end else if (state_q == grd_pkg::ST_FW_IKW || (!s1_valid_q && !s2_valid_q)) begin
          if (i_q == n_last) begin
            i_d = '0;
            if (k_q == n_last) begin
              j_d = '0;
              ecc_d = '0;
              largest_d = '0;
              smallest_d = grd_pkg::DistInf;
              state_d = grd_pkg::ST_EC_ROW;
            end else begin
              k_d = k_q + 1'b1;
              state_d = grd_pkg::ST_FW_IK;
            end
          end else begin
            i_d = i_q + 1'b1;
            state_d = grd_pkg::ST_FW_IK;
          end
        end
      end
      grd_pkg::ST_FW_ROW: begin
        raddr_a = {k_q, j_q};
        raddr_b = {i_q, j_q};
        s1_valid_d = 1'b1;
        if (j_q == n_last) begin
          state_d = grd_pkg::ST_FW_DRAIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      grd_pkg::ST_EC_ROW: begin
        raddr_a = {i_q, j_q};
        e_valid_d = 1'b1;
        ecc_d = ecc_new;
        if (j_q == n_last) begin
          state_d = grd_pkg::ST_EC_FIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      grd_pkg::ST_EC_FIN: begin
        largest_d = (ecc_new > largest_q) ? ecc_new : largest_q;
        smallest_d = (ecc_new < smallest_q) ? ecc_new : smallest_q;
        ecc_d = '0;
        j_d = '0;
        if (i_q == n_last) begin
          diameter_d = largest_d;
          radius_d = smallest_d;
          done_d = 1'b1;
          largest_d = '0;
          smallest_d = grd_pkg::DistInf;
          i_d = '0;
          state_d = grd_pkg::ST_IDLE;
        end else begin
          i_d = i_q + 1'b1;
          state_d = grd_pkg::ST_EC_ROW;
        end
      end
      default: begin
        state_d = grd_pkg::ST_IDLE;
      end
    endcase

    if (s2_valid_q && via_q < dij_q) begin
      we = 1'b1;
      waddr = {i_q, s2_j_q};
      wdata = via_q;
    end
  end

  assign s2_valid_d = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grd_pkg::ST_IDLE;
      vcount_q <= grd_pkg::VcountReset;
      row_q <= '0;
      col_q <= '0;
      last_q <= 1'b0;
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      done_q <= 1'b0;
      ecc_q <= '0;
      largest_q <= '0;
      smallest_q <= grd_pkg::DistInf;
    end else begin
      state_q <= state_d;
      vcount_q <= vcount_d;
      row_q <= row_d;
      col_q <= col_d;
      last_q <= last_d;
      k_q <= k_d;
      i_q <= i_d;
      j_q <= j_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      e_valid_q <= e_valid_d;
      done_q <= done_d;
      ecc_q <= ecc_d;
      largest_q <= largest_d;
      smallest_q <= smallest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_r_q <= ld_r_d;
    ld_c_q <= ld_c_d;
    w_q <= w_d;
    m_q <= m_d;
    dik_q <= dik_d;
    s1_j_q <= j_q;
    s2_j_q <= s1_j_q;
    via_q <= via_sum;
    dij_q <= rd_b_q;
    diameter_q <= diameter_d;
    radius_q <= radius_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

endmodule
